FILE: src/b85c_pkg.sv
package b85c_pkg;

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } mode_t;

    localparam int unsigned ENC_GROUP   = 4;
    localparam int unsigned DEC_GROUP   = 5;
    localparam int unsigned MAX_RESULTS = 5;

    localparam logic [6:0] RADIX = 7'd85;
    localparam logic [6:0] SPLIT = 7'd56;

    localparam logic [8:0] RADIX_X1 = 9'd85;
    localparam logic [8:0] RADIX_X2 = 9'd170;
    localparam logic [8:0] RADIX_X3 = 9'd255;

    localparam logic [7:0] CHAR_LO     = 8'h28;
    localparam logic [7:0] CHAR_LO_END = 8'h5F;
    localparam logic [7:0] CHAR_HI     = 8'h61;
    localparam logic [7:0] CHAR_HI_END = 8'h7D;

    // floor(v / 85) = (v * DIV85_MUL) >> DIV85_SHIFT for every 32-bit v
    localparam logic [31:0] DIV85_MUL   = 32'hC0C0C0C1;
    localparam int unsigned DIV85_SHIFT = 38;

    typedef logic [2:0] count_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_word_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] value;
        count_t      cnt;
        logic        last;
    } job_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        count_t                      cnt;
        logic                        last;
    } burst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] digit;
    } digit_t;

    function automatic logic [7:0] digit_to_char(input logic [6:0] d);
        logic [7:0] c;
        if (d < SPLIT)
        begin
            c = CHAR_LO + {1'b0, d};
        end
        else
        begin
            c = CHAR_HI + {1'b0, 7'(d - SPLIT)};
        end
        return c;
    endfunction

    function automatic digit_t char_to_digit(input logic [7:0] c);
        digit_t r;
        r.valid = 1'b1;
        r.digit = '0;
        if (c >= CHAR_LO && c <= CHAR_LO_END)
        begin
            r.digit = 7'(c - CHAR_LO);
        end
        else if (c >= CHAR_HI && c <= CHAR_HI_END)
        begin
            r.digit = 7'(c - CHAR_HI) + SPLIT;
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    // 256 = 1 mod 85, so byte sums keep the remainder
    function automatic logic [6:0] mod85(input logic [31:0] v);
        logic [9:0] s;
        logic [8:0] t;
        logic [8:0] r;
        s = 10'(v[31:24]) + 10'(v[23:16]) + 10'(v[15:8]) + 10'(v[7:0]);
        t = 9'(s[9:8]) + 9'(s[7:0]);
        if (t >= RADIX_X3)
        begin
            r = t - RADIX_X3;
        end
        else if (t >= RADIX_X2)
        begin
            r = t - RADIX_X2;
        end
        else if (t >= RADIX_X1)
        begin
            r = t - RADIX_X1;
        end
        else
        begin
            r = t;
        end
        return r[6:0];
    endfunction

endpackage

FILE: src/b85c_front.sv
module b85c_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  b85c_pkg::in_word_t      in_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [0:0]              cfg_data,
    input  b85c_pkg::queue_status_t q_status,
    output logic                    push,
    output b85c_pkg::job_t          push_job
);
    import b85c_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    count_t      fill_reg, fill_next;

    logic        accept;
    logic        last;
    digit_t      dg;
    count_t      grow_fill;
    logic [31:0] acc_shift;
    logic [31:0] acc_mac;

    function automatic count_t bytes_for(input count_t c);
        count_t n;
        if (c <= 3'd1)
        begin
            n = 3'd1;
        end
        else
        begin
            n = c - 3'd1;
        end
        return n;
    endfunction

    assign in_stall  = q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !q_status.full;
    assign last      = in_data.last_in;
    assign dg        = char_to_digit(in_data.data_in);
    assign grow_fill = fill_reg + 3'd1;
    assign acc_shift = {acc_reg[23:0], in_data.data_in};
    assign acc_mac   = 32'(acc_reg * 32'(RADIX)) + 32'(dg.digit);

    always_comb
    begin
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        push           = 1'b0;
        push_job.mode  = mode_reg;
        push_job.value = acc_reg;
        push_job.cnt   = 3'd1;
        push_job.last  = last;
        if (cfg_valid)
        begin
            mode_next = mode_t'(cfg_data[0]);
            acc_next  = '0;
            fill_next = '0;
        end
        else if (accept)
        begin
            if (mode_reg == MODE_ENC)
            begin
                if (grow_fill >= 3'(ENC_GROUP) || last)
                begin
                    push           = 1'b1;
                    push_job.value = acc_shift;
                    push_job.cnt   = grow_fill + 3'd1;
                    acc_next       = '0;
                    fill_next      = '0;
                end
                else
                begin
                    acc_next  = acc_shift;
                    fill_next = grow_fill;
                end
            end
            else if (!dg.valid)
            begin
                if (last && fill_reg != '0)
                begin
                    push           = 1'b1;
                    push_job.value = acc_reg;
                    push_job.cnt   = bytes_for(fill_reg);
                    acc_next       = '0;
                    fill_next      = '0;
                end
            end
            else if (grow_fill >= 3'(DEC_GROUP) || last)
            begin
                push           = 1'b1;
                push_job.value = acc_mac;
                push_job.cnt   = bytes_for(grow_fill);
                acc_next       = '0;
                fill_next      = '0;
            end
            else
            begin
                acc_next  = acc_mac;
                fill_next = grow_fill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENC;
            acc_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: src/b85c_fifo.sv
module b85c_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  b85c_pkg::job_t          push_job,
    input  logic                    pop,
    output b85c_pkg::job_t          head,
    output b85c_pkg::queue_status_t status
);
    import b85c_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/b85c_conv.sv
module b85c_conv (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b85c_pkg::job_t          head,
    input  b85c_pkg::queue_status_t q_status,
    output logic                    pop,
    output b85c_pkg::burst_t        burst,
    output logic                    burst_valid,
    input  logic                    burst_take
);
    import b85c_pkg::*;

    logic                        active_reg, active_next;
    count_t                      step_reg, step_next;
    count_t                      cnt_reg;
    mode_t                       mode_reg;
    logic                        last_reg;
    logic [31:0]                 val_reg;
    logic [MAX_RESULTS-1:0][7:0] buf_reg;

    logic        done;
    logic        stepping;
    logic [63:0] prod;
    logic [31:0] quo;
    logic [7:0]  step_char;
    logic [31:0] step_val;

    assign done        = active_reg && (step_reg == '0);
    assign stepping    = active_reg && (step_reg != '0);
    assign pop         = !q_status.empty && (!active_reg || (done && burst_take));
    assign burst_valid = done;
    assign burst.chars = buf_reg;
    assign burst.cnt   = cnt_reg;
    assign burst.last  = last_reg;

    assign prod = 64'(val_reg) * 64'(DIV85_MUL);
    assign quo  = 32'(prod >> DIV85_SHIFT);

    always_comb
    begin
        if (mode_reg == MODE_ENC)
        begin
            step_char = digit_to_char(mod85(val_reg));
            step_val  = quo;
        end
        else
        begin
            step_char = val_reg[7:0];
            step_val  = val_reg >> 8;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        if (pop)
        begin
            active_next = 1'b1;
            step_next   = head.cnt;
        end
        else if (done && burst_take)
        begin
            active_next = 1'b0;
        end
        else if (stepping)
        begin
            step_next = step_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    // Least significant digit shifts in first, so the top digit ends at slot 0
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            val_reg  <= head.value;
            cnt_reg  <= head.cnt;
            mode_reg <= head.mode;
            last_reg <= head.last;
        end
        else if (stepping)
        begin
            val_reg <= step_val;
            buf_reg <= {buf_reg[MAX_RESULTS-2:0], step_char};
        end
    end

endmodule

FILE: src/b85c_emit.sv
module b85c_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  b85c_pkg::burst_t    burst,
    input  logic                burst_valid,
    output logic                burst_take,
    output logic                out_valid,
    input  logic                out_stall,
    output b85c_pkg::out_word_t out_data
);
    import b85c_pkg::*;

    count_t                      cnt_reg, cnt_next;
    logic [MAX_RESULTS-1:0][7:0] buf_reg;
    logic                        last_reg;

    logic out_acc;
    logic load;

    assign out_valid         = (cnt_reg != '0);
    assign out_acc           = out_valid && !out_stall;
    assign burst_take        = (cnt_reg == '0) || ((cnt_reg == 3'd1) && out_acc);
    assign load              = burst_valid && burst_take;
    assign out_data.data_out = buf_reg[0];
    assign out_data.last_out = last_reg && (cnt_reg == 3'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = burst.cnt;
        end
        else if (out_acc)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg  <= burst.chars;
            last_reg <= burst.last;
        end
        else if (out_acc)
        begin
            buf_reg <= {8'h00, buf_reg[MAX_RESULTS-1:1]};
        end
    end

endmodule

FILE: src/base85_stream_codec.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_stall  | in_data  (data_in, last_in)
// out     | output    | out_valid / out_stall| out_data (data_out, last_out)
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (mode)
//
// One input word per cycle while the job queue has room; each group of results
// then steps through the converter, one base-85 digit per cycle from a reciprocal
// multiply when encoding or one byte shifted out when decoding, and drains from
// the output buffer while the next group converts.
// Reset empties the queue and output buffer and selects encode mode.
// out_stall holds the current output word; in_stall rises while the queue is full.
module base85_stream_codec #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  b85c_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output b85c_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_data
);
    import b85c_pkg::*;

    queue_status_t q_status;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head;
    burst_t        burst;
    logic          burst_valid;
    logic          burst_take;

    b85c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    b85c_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    b85c_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .burst       (burst),
        .burst_valid (burst_valid),
        .burst_take  (burst_take)
    );

    b85c_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .burst_valid (burst_valid),
        .burst_take  (burst_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

FILE: src/b85c_checker.sv
module b85c_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input b85c_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input b85c_pkg::out_word_t out_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [0:0]          cfg_data
);
    import b85c_pkg::*;

    mode_t mode_reg;
    logic  enc_char_ok;
    logic  in_seen;

    assign in_seen     = in_valid && (in_data.data_in == in_data.data_in);
    assign enc_char_ok = (out_data.data_out >= CHAR_LO && out_data.data_out <= CHAR_LO_END)
                      || (out_data.data_out >= CHAR_HI && out_data.data_out <= CHAR_HI_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= mode_t'(cfg_data[0]);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !out_valid && !in_stall)
        else $error("activity during reset");

    a_enc_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_reg == MODE_ENC |-> enc_char_ok)
        else $error("encoded character outside alphabet");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_seen && in_stall && !$past(in_stall) |-> $past(in_valid))
        else $error("input stalled without earlier input");

endmodule

bind base85_stream_codec b85c_checker u_b85c_checker (.*);
